@@ rtl/tvz_pkg.sv @@
// Shared types and constants for the typed varint / zigzag encoder.
package tvz_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned CntW      = 4;
  localparam int unsigned MaxBytes  = 10;
  localparam int unsigned GroupBits = 7;
  localparam int unsigned SignShift = 63;

  localparam logic [7:0] CONT_BIT = 8'h80;

  localparam logic [3:0] TYPE_INT8   = 4'd0;
  localparam logic [3:0] TYPE_UINT64 = 4'd7;
  localparam logic [3:0] TYPE_FLOAT  = 4'd8;
  localparam logic [3:0] TYPE_DOUBLE = 4'd9;

  localparam logic [CntW-1:0] FLOAT_BYTES  = 4'd4;
  localparam logic [CntW-1:0] DOUBLE_BYTES = 4'd8;

  typedef struct packed {
    logic [ValueW-1:0] word;
    logic [CntW-1:0]   cnt;
    logic              varint;
  } tvz_item_t;

endpackage

@@ rtl/tvz_prep.sv @@
// Stage 1: type decode, width masking, sign extension and zigzag mapping.
module tvz_prep import tvz_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s_valid,
  output logic              s_ready,
  input  logic [63:0]       s_value,
  input  logic [3:0]        s_type,
  input  logic              s_enc,
  output logic              m_valid,
  input  logic              m_ready,
  output tvz_item_t         m_item
);

  logic            valid_r, valid_nxt;
  tvz_item_t       item_r, item_nxt;
  logic            keep;
  logic [1:0]      wcode;
  logic [63:0]     mask;
  logic [63:0]     masked;
  logic [63:0]     sext;
  logic [63:0]     zz;

  assign s_ready = !valid_r || m_ready;
  assign m_valid = valid_r;
  assign m_item  = item_r;

  always_comb begin
    wcode = s_type[1:0];
    case (wcode)
      2'd0: begin
        mask = 64'h0000_0000_0000_00FF;
        sext = {{56{s_value[7]}}, s_value[7:0]};
      end
      2'd1: begin
        mask = 64'h0000_0000_0000_FFFF;
        sext = {{48{s_value[15]}}, s_value[15:0]};
      end
      2'd2: begin
        mask = 64'h0000_0000_FFFF_FFFF;
        sext = {{32{s_value[31]}}, s_value[31:0]};
      end
      default: begin
        mask = '1;
        sext = s_value;
      end
    endcase
    masked = s_value & mask;
    zz     = {sext[SignShift-1:0], 1'b0} ^ {ValueW{sext[SignShift]}};

    keep            = 1'b1;
    item_nxt.word   = masked;
    item_nxt.cnt    = CntW'(1) << wcode;
    item_nxt.varint = 1'b0;
    case (s_type) inside
      [TYPE_INT8:TYPE_UINT64]: begin
        if (s_enc && (wcode != 2'd0)) begin
          item_nxt.varint = 1'b1;
          item_nxt.word   = s_type[2] ? masked : zz;
        end
      end
      TYPE_FLOAT: begin
        item_nxt.word = {32'd0, s_value[31:0]};
        item_nxt.cnt  = FLOAT_BYTES;
      end
      TYPE_DOUBLE: begin
        item_nxt.word = s_value;
        item_nxt.cnt  = DOUBLE_BYTES;
      end
      default: keep = 1'b0;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (s_ready) valid_nxt = s_valid && keep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) item_r <= item_nxt;
  end

endmodule

@@ rtl/tvz_size.sv @@
// Stage 2: byte count of the encoded value.
module tvz_size import tvz_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s_valid,
  output logic      s_ready,
  input  tvz_item_t s_item,
  output logic      m_valid,
  input  logic      m_ready,
  output tvz_item_t m_item
);

  logic            valid_r, valid_nxt;
  tvz_item_t       item_r, item_nxt;
  logic [CntW-1:0] groups;

  assign s_ready = !valid_r || m_ready;
  assign m_valid = valid_r;
  assign m_item  = item_r;

  // highest non-empty 7-bit group sets the varint length
  always_comb begin
    groups = CntW'(1);
    for (int i = 1; i < MaxBytes; i++) begin
      if (|(s_item.word >> (GroupBits * i))) groups = CntW'(i + 1);
    end
    item_nxt     = s_item;
    item_nxt.cnt = s_item.varint ? groups : s_item.cnt;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (s_ready) valid_nxt = s_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) item_r <= item_nxt;
  end

endmodule

@@ rtl/tvz_ser.sv @@
// Stage 3: byte serializer with registered output beat.
module tvz_ser import tvz_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       s_valid,
  output logic       s_ready,
  input  tvz_item_t  s_item,
  output logic       m_valid,
  input  logic       m_ready,
  output logic [7:0] m_byte,
  output logic       m_last
);

  logic              busy_r, busy_nxt;
  logic [ValueW-1:0] word_r, word_nxt;
  logic [CntW-1:0]   rem_r, rem_nxt;
  logic              varint_r, varint_nxt;
  logic              done;
  logic              load;

  assign m_valid = busy_r;
  assign m_last  = (rem_r == CntW'(1));
  assign m_byte  = varint_r ? ({1'b0, word_r[GroupBits-1:0]} | (m_last ? 8'h00 : CONT_BIT))
                            : word_r[7:0];

  assign done    = busy_r && m_ready && m_last;
  assign s_ready = !busy_r || done;
  assign load    = s_ready && s_valid;

  always_comb begin
    busy_nxt   = busy_r;
    word_nxt   = word_r;
    rem_nxt    = rem_r;
    varint_nxt = varint_r;
    if (load) begin
      busy_nxt   = 1'b1;
      word_nxt   = s_item.word;
      rem_nxt    = s_item.cnt;
      varint_nxt = s_item.varint;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r && m_ready) begin
      word_nxt = varint_r ? (word_r >> GroupBits) : (word_r >> 8);
      rem_nxt  = rem_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r   <= word_nxt;
    rem_r    <= rem_nxt;
    varint_r <= varint_nxt;
  end

endmodule

@@ rtl/typed_varint_zigzag_encoder.sv @@
// Top level of the typed varint / zigzag encoder.
//   channel  dir  tdata             tuser                      tlast
//   in_      in   value[63:0]       value_type[3:0],use_varint -
//   out_     out  out_byte[7:0]     -                          last_byte
// Three register stages: decode/zigzag, byte count, serializer.
// An item of 1 to 10 bytes passes the decode, count and serializer registers;
// the serializer then sends one byte per cycle while out_tready is high.
// Type codes 10 to 15 are dropped in the first stage and give no beat.
// Synchronous active-low reset clears all valid bits; stalls hold every stage.
module typed_varint_zigzag_encoder import tvz_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // value[63:0]
  input  logic [4:0]  in_tuser,   // value_type[3:0], use_varint[4]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast
);

  logic      s1_valid, s1_ready;
  tvz_item_t s1_item;
  logic      s2_valid, s2_ready;
  tvz_item_t s2_item;

  tvz_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_value (in_tdata),
    .s_type  (in_tuser[3:0]),
    .s_enc   (in_tuser[4]),
    .m_valid (s1_valid),
    .m_ready (s1_ready),
    .m_item  (s1_item)
  );

  tvz_size u_size (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (s1_valid),
    .s_ready (s1_ready),
    .s_item  (s1_item),
    .m_valid (s2_valid),
    .m_ready (s2_ready),
    .m_item  (s2_item)
  );

  tvz_ser u_ser (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (s2_valid),
    .s_ready (s2_ready),
    .s_item  (s2_item),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_byte  (out_tdata),
    .m_last  (out_tlast)
  );

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid |-> (s2_item.cnt != '0) && (s2_item.cnt <= CntW'(MaxBytes)))
    else $error("byte count out of range");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid && !s2_ready |=> s2_valid && $stable(s2_item))
    else $error("stage 2 item changed under stall");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a value");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !s1_valid && !s2_valid)
    else $error("valid set after reset");
`endif

endmodule
